>>> rtl/scmp_pkg.sv
// shared constants for the sorted counted multiset pair: field widths,
// command and status codes, parameter defaults
// no dependencies
package scmp_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int VALUE_BITS_DEF  = 32;

	localparam int KIND_BITS   = 3;
	localparam int DATA_BITS   = 32;
	localparam int STATUS_BITS = 3;
	localparam int COUNT_BITS  = 16;
	localparam int POS_BITS    = 4;

	// longest run of entry words one command may emit
	localparam int MAX_RUN  = 16;
	localparam int RUN_BITS = $clog2(MAX_RUN + 1);

	typedef logic [KIND_BITS-1:0]   kind_t;
	typedef logic [STATUS_BITS-1:0] status_t;

	localparam kind_t KIND_PUSH  = 3'd0;
	localparam kind_t KIND_POP   = 3'd1;
	localparam kind_t KIND_CLEAR = 3'd2;
	localparam kind_t KIND_LIST  = 3'd3;
	localparam kind_t KIND_ISECT = 3'd4;

	localparam status_t STAT_INSERTED = 3'd0;
	localparam status_t STAT_COUNTED  = 3'd1;
	localparam status_t STAT_FULL     = 3'd2;
	localparam status_t STAT_EMPTY    = 3'd3;
	localparam status_t STAT_POPPED   = 3'd4;
	localparam status_t STAT_ENTRY    = 3'd5;
	localparam status_t STAT_CLEARED  = 3'd6;

endpackage

>>> rtl/scmp_if.sv
// valid/ready channel interfaces for command words and result words
// depends on scmp_pkg
interface scmp_item_if import scmp_pkg::*; ();
	logic                        valid;
	logic                        ready;
	kind_t                       kind;
	logic                        list_sel;
	logic signed [DATA_BITS-1:0] value;

	modport source (output valid, kind, list_sel, value, input ready);
	modport sink (input valid, kind, list_sel, value, output ready);
endinterface

interface scmp_result_if import scmp_pkg::*; ();
	logic                        valid;
	logic                        ready;
	status_t                     status;
	logic signed [DATA_BITS-1:0] out_value;
	logic [COUNT_BITS-1:0]       out_count;
	logic [POS_BITS-1:0]         position;
	logic                        last;

	modport source (output valid, status, out_value, out_count, position, last, input ready);
	modport sink (input valid, status, out_value, out_count, position, last, output ready);
endinterface

>>> rtl/scmp_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module scmp_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/sorted_counted_multiset_pair_core.sv
// two sorted tables of distinct signed values with repeat counts
// top level; depends on scmp_pkg, scmp_if and scmp_ram
//
// usage: command words arrive on item (push, pop smallest, clear, list,
// intersect), result words leave on result. every accepted command except an
// unknown kind gives one or more result words, the final one marked by last.
// item.ready is high only while no command is in progress; a command is
// taken at a valid and ready edge. each table lives in its own ram with one
// read and one write port, so walks proceed one entry per cycle unless stalled:
//   push       search, shift up, write
//   pop        read head, shift down
//   clear      zero the length, then report
//   list       a run of n words (n at most 16)
//   intersect  merge walk over both tables
// read entries reach result via the ram read register, then the output register.
// results sit in an output register; while the receiver holds ready low
// the walk pauses with its read data held, nothing is dropped. the next
// command may be taken while the final word still waits there.
// reset empties both tables at once (lengths go to zero); ram contents are
// not cleared and are never read beyond a table's length.
module sorted_counted_multiset_pair_core
	import scmp_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	scmp_item_if.sink     item,
	scmp_result_if.source result
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int LW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = VALUE_BITS + COUNT_BITS;
	localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SRCH  = 4'd1;
	localparam logic [3:0] ST_SHUP  = 4'd2;
	localparam logic [3:0] ST_PUT   = 4'd3;
	localparam logic [3:0] ST_POPHD = 4'd4;
	localparam logic [3:0] ST_POPSH = 4'd5;
	localparam logic [3:0] ST_LIST  = 4'd6;
	localparam logic [3:0] ST_ISECT = 4'd7;
	localparam logic [3:0] ST_IFIN  = 4'd8;
	localparam logic [3:0] ST_RESP  = 4'd9;

	logic [3:0]            state_q, state_d;
	logic [LW-1:0]         len_q [2];
	logic [LW-1:0]         len_d [2];
	logic                  sel_q, sel_d;
	logic [VALUE_BITS-1:0] val_q, val_d;
	logic [LW-1:0]         j_q, j_d;
	logic [LW-1:0]         b_q, b_d;
	logic [LW-1:0]         p_q, p_d;
	logic [RUN_BITS-1:0]   n_q, n_d;
	status_t               rstat_q, rstat_d;
	logic [VALUE_BITS-1:0] pend_val_q, pend_val_d;
	logic [COUNT_BITS-1:0] pend_cnt_q, pend_cnt_d;
	logic [POS_BITS-1:0]   pend_pos_q, pend_pos_d;

	logic                  ovalid_q;
	status_t               ostat_q, ostat_d;
	logic [DATA_BITS-1:0]  oval_q, oval_d;
	logic [COUNT_BITS-1:0] ocnt_q, ocnt_d;
	logic [POS_BITS-1:0]   opos_q, opos_d;
	logic                  olast_q, olast_d;
	logic                  out_ld;
	logic                  out_free;

	logic          re [2];
	logic          we [2];
	logic [AW-1:0] raddr [2];
	logic [AW-1:0] waddr [2];
	logic [EW-1:0] wdata [2];
	logic [EW-1:0] rdata [2];

	logic                  in_fire;
	logic [VALUE_BITS-1:0] in_val;
	logic [LW-1:0]         len_in;
	logic [LW-1:0]         len_cur;
	logic [EW-1:0]         cur;
	logic [VALUE_BITS-1:0] cur_val;
	logic [COUNT_BITS-1:0] cur_cnt;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic                  cur_lt;
	logic [VALUE_BITS-1:0] va, vb;
	logic [COUNT_BITS-1:0] ca, cb;
	logic                  a_lt, b_lt, match;
	logic [LW-1:0]         a_nx, b_nx;
	logic                  list_end;

	function automatic logic [DATA_BITS-1:0] to_out(input logic [VALUE_BITS-1:0] v);
		return DATA_BITS'($signed(v));
	endfunction

	for (genvar t = 0; t < 2; t++) begin : g_tbl
		scmp_ram #(
			.WIDTH(EW),
			.DEPTH(TABLE_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (we[t]),
			.waddr(waddr[t]),
			.wdata(wdata[t]),
			.re   (re[t]),
			.raddr(raddr[t]),
			.rdata(rdata[t])
		);
	end

	assign item.ready = (state_q == ST_IDLE);
	assign in_fire    = item.valid && item.ready;
	// wider settings take the word as unsigned, narrower ones keep only its low bits
	assign in_val     = VALUE_BITS'($unsigned(item.value));
	assign len_in     = len_q[item.list_sel];
	assign len_cur    = len_q[sel_q];

	assign cur     = rdata[sel_q];
	assign cur_val = cur[EW-1:COUNT_BITS];
	assign cur_cnt = cur[COUNT_BITS-1:0];
	assign cnt_inc = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;
	assign cur_lt  = $signed(cur_val) < $signed(val_q);

	assign va    = rdata[0][EW-1:COUNT_BITS];
	assign vb    = rdata[1][EW-1:COUNT_BITS];
	assign ca    = rdata[0][COUNT_BITS-1:0];
	assign cb    = rdata[1][COUNT_BITS-1:0];
	assign a_lt  = $signed(va) < $signed(vb);
	assign b_lt  = $signed(vb) < $signed(va);
	assign match = !a_lt && !b_lt;
	assign a_nx  = j_q + LW'(a_lt || match);
	assign b_nx  = b_q + LW'(b_lt || match);

	assign list_end = (j_q + 1'b1 == len_cur) || (j_q == LW'(MAX_RUN - 1));
	assign out_free = !ovalid_q || result.ready;

	always_comb begin
		state_d    = state_q;
		len_d      = len_q;
		sel_d      = sel_q;
		val_d      = val_q;
		j_d        = j_q;
		b_d        = b_q;
		p_d        = p_q;
		n_d        = n_q;
		rstat_d    = rstat_q;
		pend_val_d = pend_val_q;
		pend_cnt_d = pend_cnt_q;
		pend_pos_d = pend_pos_q;
		for (int t = 0; t < 2; t++) begin
			re[t]    = 1'b0;
			raddr[t] = '0;
			we[t]    = 1'b0;
			waddr[t] = '0;
			wdata[t] = '0;
		end
		out_ld  = 1'b0;
		ostat_d = STAT_EMPTY;
		oval_d  = '0;
		ocnt_d  = '0;
		opos_d  = '0;
		olast_d = 1'b1;

		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					sel_d = item.list_sel;
					val_d = in_val;
					j_d   = '0;
					b_d   = '0;
					p_d   = '0;
					n_d   = '0;
					case (item.kind)
						KIND_PUSH: begin
							if (len_in == '0) begin
								state_d = ST_PUT;
							end else begin
								re[item.list_sel] = 1'b1;
								state_d = ST_SRCH;
							end
						end
						KIND_POP: begin
							if (len_in == '0) begin
								rstat_d = STAT_EMPTY;
								state_d = ST_RESP;
							end else begin
								re[item.list_sel] = 1'b1;
								state_d = ST_POPHD;
							end
						end
						KIND_CLEAR: begin
							if (len_in == '0) begin
								rstat_d = STAT_EMPTY;
							end else begin
								len_d[item.list_sel] = '0;
								rstat_d = STAT_CLEARED;
							end
							state_d = ST_RESP;
						end
						KIND_LIST: begin
							if (len_in == '0) begin
								rstat_d = STAT_EMPTY;
								state_d = ST_RESP;
							end else begin
								re[item.list_sel] = 1'b1;
								state_d = ST_LIST;
							end
						end
						KIND_ISECT: begin
							if (len_q[0] == '0 || len_q[1] == '0) begin
								rstat_d = STAT_EMPTY;
								state_d = ST_RESP;
							end else begin
								re[0] = 1'b1;
								re[1] = 1'b1;
								state_d = ST_ISECT;
							end
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end

			// rdata holds entry j of the selected table
			ST_SRCH: begin
				if (cur_lt && (j_q + 1'b1 != len_cur)) begin
					j_d = j_q + 1'b1;
					re[sel_q] = 1'b1;
					raddr[sel_q] = AW'(j_q + 1'b1);
				end else if (!cur_lt && cur_val == val_q) begin
					if (out_free) begin
						we[sel_q]    = 1'b1;
						waddr[sel_q] = AW'(j_q);
						wdata[sel_q] = {val_q, cnt_inc};
						out_ld  = 1'b1;
						ostat_d = STAT_COUNTED;
						oval_d  = to_out(val_q);
						ocnt_d  = cnt_inc;
						opos_d  = POS_BITS'(j_q);
						state_d = ST_IDLE;
					end
				end else if (len_cur == DEPTH_L) begin
					if (out_free) begin
						out_ld  = 1'b1;
						ostat_d = STAT_FULL;
						oval_d  = to_out(val_q);
						state_d = ST_IDLE;
					end
				end else if (cur_lt) begin
					// larger than every entry: append
					p_d     = len_cur;
					state_d = ST_PUT;
				end else begin
					p_d = j_q;
					j_d = len_cur - 1'b1;
					re[sel_q] = 1'b1;
					raddr[sel_q] = AW'(len_cur - 1'b1);
					state_d = ST_SHUP;
				end
			end

			// move entry j up one slot, walking down to the insert point
			ST_SHUP: begin
				we[sel_q]    = 1'b1;
				waddr[sel_q] = AW'(j_q + 1'b1);
				wdata[sel_q] = cur;
				if (j_q == p_q) begin
					state_d = ST_PUT;
				end else begin
					j_d = j_q - 1'b1;
					re[sel_q] = 1'b1;
					raddr[sel_q] = AW'(j_q - 1'b1);
				end
			end

			ST_PUT: begin
				if (out_free) begin
					we[sel_q]    = 1'b1;
					waddr[sel_q] = AW'(p_q);
					wdata[sel_q] = {val_q, COUNT_BITS'(1)};
					len_d[sel_q] = len_cur + 1'b1;
					out_ld  = 1'b1;
					ostat_d = STAT_INSERTED;
					oval_d  = to_out(val_q);
					ocnt_d  = COUNT_BITS'(1);
					opos_d  = POS_BITS'(p_q);
					state_d = ST_IDLE;
				end
			end

			ST_POPHD: begin
				if (out_free) begin
					out_ld  = 1'b1;
					ostat_d = STAT_POPPED;
					oval_d  = to_out(cur_val);
					ocnt_d  = cur_cnt;
					if (len_cur == LW'(1)) begin
						len_d[sel_q] = '0;
						state_d = ST_IDLE;
					end else begin
						j_d = LW'(1);
						re[sel_q] = 1'b1;
						raddr[sel_q] = AW'(1);
						state_d = ST_POPSH;
					end
				end
			end

			// move entry j down one slot
			ST_POPSH: begin
				we[sel_q]    = 1'b1;
				waddr[sel_q] = AW'(j_q - 1'b1);
				wdata[sel_q] = cur;
				if (j_q + 1'b1 == len_cur) begin
					len_d[sel_q] = len_cur - 1'b1;
					state_d = ST_IDLE;
				end else begin
					j_d = j_q + 1'b1;
					re[sel_q] = 1'b1;
					raddr[sel_q] = AW'(j_q + 1'b1);
				end
			end

			ST_LIST: begin
				if (out_free) begin
					out_ld  = 1'b1;
					ostat_d = STAT_ENTRY;
					oval_d  = to_out(cur_val);
					ocnt_d  = cur_cnt;
					opos_d  = POS_BITS'(j_q);
					olast_d = list_end;
					if (list_end) begin
						state_d = ST_IDLE;
					end else begin
						j_d = j_q + 1'b1;
						re[sel_q] = 1'b1;
						raddr[sel_q] = AW'(j_q + 1'b1);
					end
				end
			end

			// merge walk: j indexes table 0, b indexes table 1; a match is held
			// back one step so the final word can carry last
			ST_ISECT: begin
				if (!(match && n_q != '0 && !out_free)) begin
					if (match) begin
						pend_val_d = va;
						pend_cnt_d = (ca < cb) ? ca : cb;
						pend_pos_d = POS_BITS'(n_q);
						n_d = n_q + 1'b1;
						if (n_q != '0) begin
							out_ld  = 1'b1;
							ostat_d = STAT_ENTRY;
							oval_d  = to_out(pend_val_q);
							ocnt_d  = pend_cnt_q;
							opos_d  = pend_pos_q;
							olast_d = 1'b0;
						end
					end
					j_d = a_nx;
					b_d = b_nx;
					if (a_nx == len_q[0] || b_nx == len_q[1] ||
						(match && n_q == RUN_BITS'(MAX_RUN - 1))) begin
						state_d = ST_IFIN;
					end else begin
						re[0]    = 1'b1;
						re[1]    = 1'b1;
						raddr[0] = AW'(a_nx);
						raddr[1] = AW'(b_nx);
					end
				end
			end

			ST_IFIN: begin
				if (out_free) begin
					out_ld = 1'b1;
					if (n_q != '0) begin
						ostat_d = STAT_ENTRY;
						oval_d  = to_out(pend_val_q);
						ocnt_d  = pend_cnt_q;
						opos_d  = pend_pos_q;
					end
					state_d = ST_IDLE;
				end
			end

			ST_RESP: begin
				if (out_free) begin
					out_ld  = 1'b1;
					ostat_d = rstat_q;
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			len_q[0] <= '0;
			len_q[1] <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			if (out_ld) begin
				ovalid_q <= 1'b1;
			end else if (result.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		sel_q      <= sel_d;
		val_q      <= val_d;
		j_q        <= j_d;
		b_q        <= b_d;
		p_q        <= p_d;
		n_q        <= n_d;
		rstat_q    <= rstat_d;
		pend_val_q <= pend_val_d;
		pend_cnt_q <= pend_cnt_d;
		pend_pos_q <= pend_pos_d;
		if (out_ld) begin
			ostat_q <= ostat_d;
			oval_q  <= oval_d;
			ocnt_q  <= ocnt_d;
			opos_q  <= opos_d;
			olast_q <= olast_d;
		end
	end

	assign result.valid     = ovalid_q;
	assign result.status    = ostat_q;
	assign result.out_value = oval_q;
	assign result.out_count = ocnt_q;
	assign result.position  = opos_q;
	assign result.last      = olast_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q[0] <= DEPTH_L && len_q[1] <= DEPTH_L)
		else $error("table length beyond depth");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_ld |-> out_free)
		else $error("result word loaded over one not yet taken");

	a_unknown_kind: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && item.kind > KIND_ISECT |=>
		state_q == ST_IDLE && $stable(len_q[0]) && $stable(len_q[1]))
		else $error("unknown command changed state");

	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(we[0] && re[0] |-> waddr[0] != raddr[0]) and
		(we[1] && re[1] |-> waddr[1] != raddr[1]))
		else $error("shift reads the slot it writes");

endmodule
